FILE: design/rtc_pkg.sv
// Package for the calendar clock: item kinds, register indexes, time record
// and the month length function. No dependencies; used by every design file.
package rtc_pkg;

  // Item kinds carried on the input tuser.
  typedef enum logic [1:0] {
    KIND_TICK       = 2'd0,
    KIND_SET_TIME   = 2'd1,
    KIND_SET_DATE   = 2'd2,
    KIND_CLEAR_TIME = 2'd3
  } kind_t;

  // Configuration register indexes.
  localparam int unsigned CFG_IDX_W = 3;
  localparam int unsigned CFG_DATA_W = 6;
  localparam logic [CFG_IDX_W-1:0] REG_RUN_ENABLE   = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_ALARM_ENABLE = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_ALARM_HOUR   = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_ALARM_MINUTE = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_ALARM_SECOND = 3'd4;

  // Full clock record. The hour sits in the lowest bits, so the packed
  // record is the tdata layout of both channels.
  typedef struct packed {
    logic [2:0] weekday;
    logic [4:0] day;
    logic [3:0] month;
    logic [6:0] year;
    logic [5:0] second;
    logic [5:0] minute;
    logic [4:0] hour;
  } time_t;

  localparam int unsigned TIME_W = $bits(time_t);
  localparam int unsigned TDATA_W = ((TIME_W + 7) / 8) * 8;

  // Settings taken from the configuration registers.
  typedef struct packed {
    logic       run_enable;
    logic       alarm_enable;
    logic [4:0] alarm_hour;
    logic [5:0] alarm_minute;
    logic [5:0] alarm_second;
  } cfg_t;

  // Counter limits and reset values.
  localparam logic [5:0] SEC_MAX   = 6'd59;
  localparam logic [5:0] MIN_MAX   = 6'd59;
  localparam logic [4:0] HOUR_MAX  = 5'd23;
  localparam logic [3:0] MONTH_MAX = 4'd12;
  localparam logic [6:0] YEAR_MAX  = 7'd99;
  localparam logic [6:0] YEAR_RESET = 7'd22;

  // Days in a month; months outside 1 to 12 have no days at all.
  function automatic logic [4:0] days_in_month(input logic [3:0] month,
                                               input logic [6:0] year);
    logic [4:0] len;
    case (month)
      4'd1, 4'd3, 4'd5, 4'd7, 4'd8, 4'd10, 4'd12: len = 5'd31;
      4'd4, 4'd6, 4'd9, 4'd11:                    len = 5'd30;
      4'd2:    len = (year[1:0] == 2'b00) ? 5'd29 : 5'd28;
      default: len = 5'd0;
    endcase
    return len;
  endfunction

endpackage

FILE: design/rtc_cfg.sv
// Configuration register file of the calendar clock.
// Depends on rtc_pkg for register indexes and the settings record.
module rtc_cfg (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          cfg_we,
  input  logic [rtc_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [rtc_pkg::CFG_DATA_W-1:0] cfg_data,
  output rtc_pkg::cfg_t                 cfg
);

  rtc_pkg::cfg_t regs;

  // One register per write; unknown indexes are dropped.
  always_ff @(posedge clk) begin
    if (rst) begin
      regs.run_enable   <= 1'b1;
      regs.alarm_enable <= 1'b0;
      regs.alarm_hour   <= '0;
      regs.alarm_minute <= '0;
      regs.alarm_second <= '0;
    end else if (cfg_we) begin
      case (cfg_index)
        rtc_pkg::REG_RUN_ENABLE:   regs.run_enable   <= cfg_data[0];
        rtc_pkg::REG_ALARM_ENABLE: regs.alarm_enable <= cfg_data[0];
        rtc_pkg::REG_ALARM_HOUR:   regs.alarm_hour   <= cfg_data[4:0];
        rtc_pkg::REG_ALARM_MINUTE: regs.alarm_minute <= cfg_data;
        rtc_pkg::REG_ALARM_SECOND: regs.alarm_second <= cfg_data;
        default: ;
      endcase
    end
  end

  assign cfg = regs;

endmodule

FILE: design/rtc_advance.sv
// One-second advance of the clock record: a ripple of compare-and-wrap
// counters from seconds up to years. Depends on rtc_pkg.
module rtc_advance (
  input  rtc_pkg::time_t cur,
  output rtc_pkg::time_t nxt
);

  logic [6:0] sec_inc;
  logic [6:0] min_inc;
  logic [5:0] hour_inc;
  logic [5:0] day_inc;
  logic [4:0] month_inc;
  logic [7:0] year_inc;
  logic [4:0] month_len;
  logic       sec_wrap, min_wrap, hour_wrap, day_wrap, month_wrap;

  assign sec_inc   = {1'b0, cur.second} + 7'd1;
  assign min_inc   = {1'b0, cur.minute} + 7'd1;
  assign hour_inc  = {1'b0, cur.hour} + 6'd1;
  assign day_inc   = {1'b0, cur.day} + 6'd1;
  assign month_inc = {1'b0, cur.month} + 5'd1;
  assign year_inc  = {1'b0, cur.year} + 8'd1;
  assign month_len = rtc_pkg::days_in_month(cur.month, cur.year);

  // A counter wraps once its incremented value passes its top.
  assign sec_wrap   = sec_inc > {1'b0, rtc_pkg::SEC_MAX};
  assign min_wrap   = min_inc > {1'b0, rtc_pkg::MIN_MAX};
  assign hour_wrap  = hour_inc > {1'b0, rtc_pkg::HOUR_MAX};
  assign day_wrap   = day_inc > {1'b0, month_len};
  assign month_wrap = month_inc > {1'b0, rtc_pkg::MONTH_MAX};

  // Each field moves only when every lower field wrapped.
  always_comb begin
    nxt = cur;
    nxt.second = sec_wrap ? 6'd0 : sec_inc[5:0];
    if (sec_wrap) begin
      nxt.minute = min_wrap ? 6'd0 : min_inc[5:0];
      if (min_wrap) begin
        nxt.hour = hour_wrap ? 5'd0 : hour_inc[4:0];
        if (hour_wrap) begin
          nxt.day = day_wrap ? 5'd1 : day_inc[4:0];
          if (day_wrap) begin
            nxt.month = month_wrap ? 4'd1 : month_inc[3:0];
            if (month_wrap) begin
              nxt.year = (year_inc > {1'b0, rtc_pkg::YEAR_MAX}) ? 7'd0 : year_inc[6:0];
            end
          end
        end
      end
    end
  end

endmodule

FILE: design/rtc_core.sv
// Clock state and result register of the calendar clock. Applies one item per cycle to
// the stored time while the result register can be refilled. Uses rtc_pkg and rtc_advance.
module rtc_core (
  input  logic                        clk,
  input  logic                        rst,
  input  rtc_pkg::cfg_t               cfg,
  input  logic                        item_valid,
  input  rtc_pkg::kind_t              item_kind,
  input  rtc_pkg::time_t              item_time,
  output logic                        item_ready,
  output logic                        m_tvalid,
  input  logic                        m_tready,
  output logic [rtc_pkg::TDATA_W-1:0] m_tdata,
  output logic [1:0]                  m_tuser
);

  rtc_pkg::time_t clk_state;
  rtc_pkg::time_t state_next;
  rtc_pkg::time_t ticked;
  logic           event_next;
  logic           hit_next;
  logic           take;

  rtc_advance u_advance (
    .cur (clk_state),
    .nxt (ticked)
  );

  // The result register may be refilled when empty or being drained.
  assign item_ready = !m_tvalid || m_tready;
  assign take = item_valid && item_ready;

  // Next clock record and flags for the item at hand.
  always_comb begin
    state_next = clk_state;
    event_next = 1'b0;
    case (item_kind)
      rtc_pkg::KIND_TICK: begin
        if (cfg.run_enable) begin
          state_next = ticked;
          event_next = 1'b1;
        end
      end
      rtc_pkg::KIND_SET_TIME: begin
        state_next.hour   = item_time.hour;
        state_next.minute = item_time.minute;
        state_next.second = item_time.second;
      end
      rtc_pkg::KIND_SET_DATE: begin
        state_next.year    = item_time.year;
        state_next.month   = item_time.month;
        state_next.day     = item_time.day;
        state_next.weekday = item_time.weekday;
      end
      rtc_pkg::KIND_CLEAR_TIME: begin
        state_next.hour   = '0;
        state_next.minute = '0;
        state_next.second = '0;
      end
      default: ;
    endcase
    hit_next = event_next && cfg.alarm_enable &&
               state_next.hour == cfg.alarm_hour &&
               state_next.minute == cfg.alarm_minute &&
               state_next.second == cfg.alarm_second;
  end

  // Stored clock.
  always_ff @(posedge clk) begin
    if (rst) begin
      clk_state.hour    <= '0;
      clk_state.minute  <= '0;
      clk_state.second  <= '0;
      clk_state.year    <= rtc_pkg::YEAR_RESET;
      clk_state.month   <= '0;
      clk_state.day     <= '0;
      clk_state.weekday <= '0;
    end else if (take) begin
      clk_state <= state_next;
    end
  end

  // Result register valid flag.
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (item_ready) begin
      m_tvalid <= item_valid;
    end
  end

  // Result payload.
  always_ff @(posedge clk) begin
    if (take) begin
      m_tdata <= {{(rtc_pkg::TDATA_W - rtc_pkg::TIME_W){1'b0}}, state_next};
      m_tuser <= {hit_next, event_next};
    end
  end

endmodule

FILE: design/calendar_clock_with_alarm.sv
// Top level of the binary calendar clock with time-of-day alarm.
// Depends on rtc_pkg, rtc_cfg, rtc_advance (through rtc_core) and rtc_core.
//
//  channel  | direction | handshake          | contents
//  ---------+-----------+--------------------+---------------------------------
//  s_axis   | in        | s_tvalid/s_tready  | item: kind in tuser, time in tdata
//  m_axis   | out       | m_tvalid/m_tready  | result: time in tdata, flags tuser
//  cfg      | in        | cfg_we             | register index and write data
//
// Every item gives one result. The item waits in the input register while the clock
// update is worked out, and the result register loads when the core takes the item,
// so each result has passed through both registers.
// One item per cycle is sustained; the input register keeps accepting while
// a result waits, and the chain stalls only when both stages are full.
// Reset (rst, synchronous) sets the clock to year 22, all else 0, and the
// registers to run enabled, alarm disabled, alarm time 0.
module calendar_clock_with_alarm (
  input  logic                          clk,
  input  logic                          rst,
  // Configuration writes.
  input  logic                          cfg_we,
  input  logic [rtc_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [rtc_pkg::CFG_DATA_W-1:0] cfg_data,
  // Input items.
  input  logic                          s_tvalid,
  output logic                          s_tready,
  // new_hour[4:0], new_minute[10:5], new_second[16:11], new_year[23:17],
  // new_month[27:24], new_day[32:28], new_weekday[35:33], zero fill
  input  logic [rtc_pkg::TDATA_W-1:0]   s_tdata,
  // kind[1:0]
  input  logic [1:0]                    s_tuser,
  // Results.
  output logic                          m_tvalid,
  input  logic                          m_tready,
  // cur_hour[4:0], cur_minute[10:5], cur_second[16:11], cur_year[23:17],
  // cur_month[27:24], cur_day[32:28], cur_weekday[35:33], zero fill
  output logic [rtc_pkg::TDATA_W-1:0]   m_tdata,
  // second_event[0], alarm_hit[1]
  output logic [1:0]                    m_tuser
);

  rtc_pkg::cfg_t  cfg;
  logic           in_valid;
  rtc_pkg::kind_t in_kind;
  rtc_pkg::time_t in_time;
  logic           core_ready;

  rtc_cfg u_cfg (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cfg       (cfg)
  );

  // Input register: free, or emptying into the core this cycle.
  assign s_tready = !in_valid || core_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (s_tready) begin
      in_valid <= s_tvalid;
    end
  end

  // Input payload for each accepted transaction.
  always_ff @(posedge clk) begin
    if (s_tvalid && s_tready) begin
      in_kind <= rtc_pkg::kind_t'(s_tuser);
      in_time <= rtc_pkg::time_t'(s_tdata[rtc_pkg::TIME_W-1:0]);
    end
  end

  rtc_core u_core (
    .clk        (clk),
    .rst        (rst),
    .cfg        (cfg),
    .item_valid (in_valid),
    .item_kind  (in_kind),
    .item_time  (in_time),
    .item_ready (core_ready),
    .m_tvalid   (m_tvalid),
    .m_tready   (m_tready),
    .m_tdata    (m_tdata),
    .m_tuser    (m_tuser)
  );

endmodule
